/* src/rha_pkg.sv */
// ----------------------------------------------------------------------------
// rha_pkg
// Shared types, codes and hash helpers for the record hash accumulator.
// ----------------------------------------------------------------------------
package rha_pkg;

	localparam logic [63:0] HASH_BASIS  = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] HASH_GOLDEN = 64'h9E37_79B9_7F4A_7C15;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	localparam int unsigned NUM_WORDS = 5;
	localparam int unsigned COUNT_W   = 31;
	localparam int unsigned INDEX_W   = 31;
	localparam int unsigned TIME_W    = 63;
	localparam int unsigned STEP_W    = 3;

	// Opcodes of the input channel
	localparam logic [1:0] OP_RECORD = 2'd0;
	localparam logic [1:0] OP_ACTIVE = 2'd1;
	localparam logic [1:0] OP_FINAL  = 2'd2;

	// Fold steps per queued request kind
	localparam logic [STEP_W-1:0] RECORD_LAST = 3'd4;
	localparam logic [STEP_W-1:0] FINAL_LAST  = 3'd2;

	typedef enum logic [1:0] {
		KIND_RECORD,
		KIND_ACTIVE,
		KIND_FINAL
	} kind_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [63:0]        pos_x;
		logic [63:0]        pos_y;
		logic [63:0]        pos_z;
		logic [7:0]         particle_type;
		logic [63:0]        mass_bits;
		logic [63:0]        radius_bits;
		logic [INDEX_W-1:0] active_index;
		logic [TIME_W-1:0]  current_time;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        hash_positions;
		logic [63:0]        hash_radius;
		logic [63:0]        hash_active;
		logic [63:0]        hash_total;
		logic [COUNT_W-1:0] records_seen;
	} out_item_t;

	// Classified request as held in the queue; aux carries the index or the time
	typedef struct packed {
		kind_t                        kind;
		logic [NUM_WORDS-1:0][63:0]   words;
		logic [63:0]                  radius;
		logic [63:0]                  aux;
	} entry_t;

	function automatic logic [63:0] fold(input logic [63:0] h, input logic [63:0] v);
		return h ^ (v + HASH_GOLDEN + (h << 6) + (h >> 2));
	endfunction

	// Exact double encoding of an unsigned 8-bit integer
	function automatic logic [63:0] type_to_double(input logic [7:0] n);
		logic [2:0]  e;
		logic [63:0] sh;
		logic [10:0] ex;
		e = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (n[i]) begin
				e = 3'(i);
			end
		end
		sh = {56'b0, n} << (7'd52 - {4'b0, e});
		ex = 11'd1023 + {8'b0, e};
		if (n == 8'd0) begin
			return 64'd0;
		end
		return {1'b0, ex, sh[51:0]};
	endfunction

endpackage

/* src/rha_if.sv */
// ----------------------------------------------------------------------------
// rha_if
// Valid/ready channels of the record hash accumulator.
// ----------------------------------------------------------------------------
interface rha_in_if;
	import rha_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rha_out_if;
	import rha_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

/* src/rha_front.sv */
// ----------------------------------------------------------------------------
// rha_front
// Accepts requests, classifies them, converts the type and queues them.
// ----------------------------------------------------------------------------
module rha_front #(
	parameter int unsigned QUEUE_DEPTH = rha_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	rha_in_if.sink          records,
	output logic            q_valid,
	output rha_pkg::entry_t q_entry,
	input  logic            q_pop
);
	import rha_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;

	logic   accept;
	logic   keep;
	logic   push;
	entry_t entry;

	assign records.ready = (fill_q != CNT_W'(QUEUE_DEPTH));
	assign accept        = records.valid && records.ready;
	assign push          = accept && keep;

	always_comb begin
		keep          = 1'b1;
		entry.kind    = KIND_RECORD;
		entry.words[0] = records.data.pos_x;
		entry.words[1] = records.data.pos_y;
		entry.words[2] = records.data.pos_z;
		entry.words[3] = type_to_double(records.data.particle_type);
		entry.words[4] = records.data.mass_bits;
		entry.radius  = records.data.radius_bits;
		entry.aux     = '0;
		case (records.data.opcode)
			OP_RECORD: begin
				entry.kind = KIND_RECORD;
			end
			OP_ACTIVE: begin
				entry.kind = KIND_ACTIVE;
				entry.aux  = {{(64 - INDEX_W){1'b0}}, records.data.active_index};
			end
			OP_FINAL: begin
				entry.kind = KIND_FINAL;
				entry.aux  = {{(64 - TIME_W){1'b0}}, records.data.current_time};
			end
			default: begin
				// unused opcode: take the request and drop it
				keep = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && q_pop) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign q_valid = (fill_q != '0);
	assign q_entry = mem_q[rd_ptr_q];

endmodule

/* src/rha_back.sv */
// ----------------------------------------------------------------------------
// rha_back
// Folds queued requests into the accumulators, one position fold a cycle
// unless a finalize waits on a busy output register, which holds its result.
// ----------------------------------------------------------------------------
module rha_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  rha_pkg::entry_t q_entry,
	output logic            q_pop,
	rha_out_if.source       hashes
);
	import rha_pkg::*;

	logic [63:0]        acc_pos_q;
	logic [63:0]        acc_rad_q;
	logic [63:0]        acc_act_q;
	logic [COUNT_W-1:0] count_q;
	logic [STEP_W-1:0]  step_q;
	logic [63:0]        tmp_q;
	logic               out_valid_q;
	out_item_t          out_q;

	logic        out_free;
	logic        last;
	logic        advance;
	logic [63:0] h_in;
	logic [63:0] v_in;
	logic [63:0] folded;
	logic [63:0] tail;

	assign out_free = !out_valid_q || hashes.ready;
	assign tail     = {1'b0, count_q, 32'b0} ^ q_entry.aux;

	always_comb begin
		last = 1'b1;
		h_in = acc_pos_q;
		v_in = q_entry.words[step_q];
		case (q_entry.kind)
			KIND_RECORD: begin
				last = (step_q == RECORD_LAST);
			end
			KIND_ACTIVE: begin
				last = 1'b1;
			end
			KIND_FINAL: begin
				last = (step_q == FINAL_LAST);
				if (step_q != '0) begin
					h_in = tmp_q;
				end
				case (step_q)
					3'd0:    v_in = acc_rad_q;
					3'd1:    v_in = acc_act_q;
					default: v_in = tail;
				endcase
			end
			default: begin
				last = 1'b1;
			end
		endcase
	end

	assign folded = fold(h_in, v_in);
	// stall only the final fold of a finalize when the result slot is busy
	assign advance = q_valid && !(q_entry.kind == KIND_FINAL && last && !out_free);
	assign q_pop   = advance && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_pos_q   <= HASH_BASIS;
			acc_rad_q   <= HASH_BASIS;
			acc_act_q   <= HASH_BASIS;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && q_entry.kind == KIND_FINAL && last) begin
				out_valid_q <= 1'b1;
			end else if (hashes.ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance) begin
				step_q <= last ? '0 : step_q + 1'b1;
				case (q_entry.kind)
					KIND_RECORD: begin
						acc_pos_q <= folded;
						if (step_q == '0) begin
							acc_rad_q <= fold(acc_rad_q, q_entry.radius);
							count_q   <= count_q + 1'b1;
						end
					end
					KIND_ACTIVE: begin
						acc_act_q <= fold(acc_act_q, q_entry.aux);
					end
					KIND_FINAL: begin
						if (last) begin
							acc_pos_q <= HASH_BASIS;
							acc_rad_q <= HASH_BASIS;
							acc_act_q <= HASH_BASIS;
							count_q   <= '0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && q_entry.kind == KIND_FINAL) begin
			tmp_q <= folded;
			if (last) begin
				out_q.hash_positions <= acc_pos_q;
				out_q.hash_radius    <= acc_rad_q;
				out_q.hash_active    <= acc_act_q;
				out_q.hash_total     <= folded;
				out_q.records_seen   <= count_q;
			end
		end
	end

	assign hashes.valid = out_valid_q;
	assign hashes.data  = out_q;

endmodule

/* src/record_hash_accumulator.sv */
// ----------------------------------------------------------------------------
// record_hash_accumulator
// Folds particle records and active indexes into three 64-bit hashes.
// ----------------------------------------------------------------------------
// Input channel "records" takes one request per cycle while the queue has
// room: a particle record, an active index, or a finalize. An unused opcode
// is taken and dropped. Output channel "hashes" carries one result per
// finalize: the three hashes, the combined hash and the record count.
//
// The front queue (QUEUE_DEPTH entries) lets requests keep arriving while
// the back end works. The back end has one position fold unit, so a record
// occupies it for a fold of each of its words and a finalize for folds of
// the radius hash, the active hash and the tail.
//
// Reset sets all hashes to the FNV offset basis and the count to zero; the
// queue and the output register empty. When the receiver stalls, the result
// holds in the output register; a following finalize waits at its last
// fold, and the queue then fills and drops ready.
// ----------------------------------------------------------------------------
module record_hash_accumulator #(
	parameter int unsigned QUEUE_DEPTH = rha_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	rha_in_if.sink     records,
	rha_out_if.source  hashes
);
	import rha_pkg::*;

	logic   q_valid;
	entry_t q_entry;
	logic   q_pop;

	rha_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.records (records),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop)
	);

	rha_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (q_entry),
		.q_pop   (q_pop),
		.hashes  (hashes)
	);

endmodule

/* verif/record_hash_accumulator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// record_hash_accumulator_test
// Self-checking bench for the record hash accumulator. Requests are predicted
// in the bench's own hash model; every finalize result is compared field by
// field under three pacing mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module record_hash_accumulator_test;
	import rha_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;

	rha_in_if  records ();
	rha_out_if hashes ();

	record_hash_accumulator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.records(records),
		.hashes (hashes)
	);

	// Bench copy of the accumulator state
	logic [63:0]        pos_hash;
	logic [63:0]        radius_hash;
	logic [63:0]        active_hash;
	logic [COUNT_W-1:0] record_tally;

	out_item_t pending_hashes[$];

	int unsigned send_idle_pct;
	int unsigned take_idle_pct;
	int unsigned sent_count;
	int unsigned results_checked;
	int unsigned mismatch_count;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1_600_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic logic [63:0] mix_in(input logic [63:0] h, input logic [63:0] v);
		return h ^ (v + HASH_GOLDEN + (h << 6) + (h >> 2));
	endfunction

	function automatic void clear_hashes();
		pos_hash     = HASH_BASIS;
		radius_hash  = HASH_BASIS;
		active_hash  = HASH_BASIS;
		record_tally = '0;
	endfunction

	function automatic void predict_hashes(input in_item_t req);
		out_item_t   res;
		logic [63:0] tail;
		case (req.opcode)
			OP_RECORD: begin
				pos_hash = mix_in(pos_hash, req.pos_x);
				pos_hash = mix_in(pos_hash, req.pos_y);
				pos_hash = mix_in(pos_hash, req.pos_z);
				pos_hash = mix_in(pos_hash, $realtobits(real'(req.particle_type)));
				pos_hash = mix_in(pos_hash, req.mass_bits);
				radius_hash = mix_in(radius_hash, req.radius_bits);
				// wraps at 2^31 by its width
				record_tally = record_tally + 1'b1;
			end
			OP_ACTIVE: begin
				active_hash = mix_in(active_hash, {33'd0, req.active_index});
			end
			OP_FINAL: begin
				tail = {1'b0, record_tally, 32'd0} ^ {1'b0, req.current_time};
				res.hash_positions = pos_hash;
				res.hash_radius    = radius_hash;
				res.hash_active    = active_hash;
				res.hash_total     = mix_in(mix_in(mix_in(pos_hash, radius_hash), active_hash), tail);
				res.records_seen   = record_tally;
				pending_hashes.push_back(res);
				clear_hashes();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [63:0] pick_double();
		real v;
		case ($urandom_range(0, 9))
			0: return 64'd0;
			1: return '1;
			2: return 64'h7FF0_0000_0000_0000;
			3, 4, 5: begin
				v = (real'($urandom) / 4294967296.0 - 0.5) * 1000.0;
				return $realtobits(v);
			end
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Fill every field; the ones the opcode does not use carry junk
	function automatic in_item_t make_request(input logic [1:0] op);
		in_item_t r;
		r.opcode      = op;
		r.pos_x       = pick_double();
		r.pos_y       = pick_double();
		r.pos_z       = pick_double();
		r.mass_bits   = pick_double();
		r.radius_bits = pick_double();
		if ($urandom_range(0, 1) != 0) begin
			r.particle_type = 8'($urandom_range(0, 255));
		end else begin
			r.particle_type = 8'($urandom_range(0, 7));
		end
		case ($urandom_range(0, 3))
			0: r.active_index = INDEX_W'($urandom_range(0, 1000));
			1: r.active_index = '1;
			default: r.active_index = INDEX_W'($urandom);
		endcase
		r.current_time = TIME_W'({$urandom, $urandom});
		return r;
	endfunction

	task automatic send_request(input in_item_t req);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			records.valid <= 1'b0;
			@(posedge clk);
		end
		records.valid <= 1'b1;
		records.data  <= req;
		do @(posedge clk); while (!records.ready);
		sent_count++;
		predict_hashes(req);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
		end
	endtask

	task automatic check_result();
		out_item_t want;
		out_item_t got;
		got = hashes.data;
		results_checked++;
		if (pending_hashes.size() == 0) begin
			report_mismatch("unexpected result, hash_total", 64'd0, got.hash_total);
			return;
		end
		want = pending_hashes.pop_front();
		if (got.hash_positions !== want.hash_positions) begin
			report_mismatch("hash_positions", want.hash_positions, got.hash_positions);
		end
		if (got.hash_radius !== want.hash_radius) begin
			report_mismatch("hash_radius", want.hash_radius, got.hash_radius);
		end
		if (got.hash_active !== want.hash_active) begin
			report_mismatch("hash_active", want.hash_active, got.hash_active);
		end
		if (got.hash_total !== want.hash_total) begin
			report_mismatch("hash_total", want.hash_total, got.hash_total);
		end
		if (got.records_seen !== want.records_seen) begin
			report_mismatch("records_seen", 64'(want.records_seen), 64'(got.records_seen));
		end
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && hashes.valid && hashes.ready) begin
				check_result();
			end
		end
	end

	initial begin
		hashes.ready <= 1'b0;
		forever begin
			@(posedge clk);
			hashes.ready <= ($urandom_range(0, 99) >= take_idle_pct);
		end
	end

	task automatic test_field_extremes();
		in_item_t   r;
		logic [7:0] type_edges [5];
		r = make_request(OP_RECORD);
		r.pos_x         = '0;
		r.pos_y         = '0;
		r.pos_z         = '0;
		r.particle_type = '0;
		r.mass_bits     = '0;
		r.radius_bits   = '0;
		send_request(r);
		r.pos_x         = '1;
		r.pos_y         = '1;
		r.pos_z         = '1;
		r.particle_type = '1;
		r.mass_bits     = '1;
		r.radius_bits   = '1;
		send_request(r);
		r = make_request(OP_ACTIVE);
		r.active_index = '0;
		send_request(r);
		r.active_index = '1;
		send_request(r);
		r = make_request(OP_FINAL);
		r.current_time = '0;
		send_request(r);
		// finalize on freshly cleared state
		r.current_time = '1;
		send_request(r);
		// exponent edges of the type conversion
		type_edges = '{8'd1, 8'd2, 8'd3, 8'd128, 8'd255};
		foreach (type_edges[i]) begin
			r = make_request(OP_RECORD);
			r.particle_type = type_edges[i];
			send_request(r);
		end
		send_request(make_request(OP_FINAL));
	endtask

	task automatic test_opcode_handling();
		in_item_t r;
		r = make_request(OP_UNUSED);
		r.pos_x        = '1;
		r.radius_bits  = '1;
		r.active_index = '1;
		send_request(r);
		send_request(make_request(OP_FINAL));
		send_request(make_request(OP_RECORD));
		send_request(make_request(OP_UNUSED));
		send_request(make_request(OP_ACTIVE));
		send_request(make_request(OP_UNUSED));
		send_request(make_request(OP_FINAL));
	endtask

	// Frames of records and active indexes closed by a finalize, with some noise
	task automatic test_random_frames(input int unsigned item_goal);
		int unsigned done_items;
		int unsigned frame_len;
		done_items = 0;
		while (done_items < item_goal) begin
			if ($urandom_range(0, 9) == 0) begin
				frame_len = $urandom_range(9, 40);
			end else begin
				frame_len = $urandom_range(0, 8);
			end
			repeat (frame_len) begin
				if ($urandom_range(0, 24) == 0) begin
					send_request(make_request(OP_UNUSED));
				end
				if ($urandom_range(0, 9) < 7) begin
					send_request(make_request(OP_RECORD));
				end else begin
					send_request(make_request(OP_ACTIVE));
				end
				done_items++;
			end
			send_request(make_request(OP_FINAL));
			done_items++;
		end
	endtask

	initial begin
		send_idle_pct   = 29;
		take_idle_pct   = 84;
		sent_count      = 0;
		results_checked = 0;
		mismatch_count  = 0;
		clear_hashes();
		arst_n        <= 1'b0;
		records.valid <= 1'b0;
		records.data  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_field_extremes();
		test_opcode_handling();
		test_random_frames(600);

		send_idle_pct = 84;
		take_idle_pct = 29;
		test_random_frames(600);

		send_idle_pct = 0;
		take_idle_pct = 0;
		test_random_frames(600);

		records.valid <= 1'b0;
		for (int w = 0; w < 20000 && pending_hashes.size() != 0; w++) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (pending_hashes.size() != 0) begin
			mismatch_count += pending_hashes.size();
			$display("%0d expected results never arrived", pending_hashes.size());
		end

		$display("Sent %0d requests (records, active indexes, finalizes, unused codes)",
			sent_count);
		$display("Checked %0d finalize results across three pacing mixes", results_checked);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

/* files.f */
src/rha_pkg.sv
src/rha_if.sv
src/rha_front.sv
src/rha_back.sv
src/record_hash_accumulator.sv
verif/record_hash_accumulator_test.sv
